[design/kslex_pkg.sv]
// Package for the keyword and string lexer: result and bundle types, codes,
// lexer mode enum, the keyword table and the keyword matcher.
// No dependencies.
`default_nettype none

package kslex_pkg;

   localparam int COLUMN_BITS_DEF = 16;
   localparam int WORD_MAX        = 6;
   localparam int KW_COUNT        = 17;
   localparam int KW_IDX_BITS     = 5;
   localparam int MAX_RESULTS     = 3;
   localparam int Q_DEPTH         = 4;
   localparam int Q_PTR_BITS      = 2;

   // result kinds
   localparam logic [2:0] K_CHAR    = 3'd0;
   localparam logic [2:0] K_STREND  = 3'd1;
   localparam logic [2:0] K_KEYWORD = 3'd2;
   localparam logic [2:0] K_ERROR   = 3'd3;
   localparam logic [2:0] K_END     = 3'd4;

   // error codes
   localparam logic [1:0] E_NONE    = 2'd0;
   localparam logic [1:0] E_UNTERM  = 2'd1;
   localparam logic [1:0] E_WORD    = 2'd2;
   localparam logic [1:0] E_CHAR    = 2'd3;

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_QUOTE  = 8'h22;

   // word length 7 marks an over-long word
   localparam logic [2:0] WLEN_LONG = 3'd7;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_STR   = 2'd1,
      MODE_WORD  = 2'd2,
      MODE_DRAIN = 2'd3
   } mode_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] value;
      logic [1:0] err_code;
   } result_type;

   // all results caused by one byte; column is carried alongside
   typedef struct packed {
      logic [1:0]                    count;
      result_type [MAX_RESULTS-1:0]  res;
   } bundle_type;

   typedef struct packed {
      logic                   hit;
      logic [KW_IDX_BITS-1:0] idx;
   } match_type;

   typedef logic [7:0] word_type [WORD_MAX];

   localparam logic [7:0] KW_CHARS [KW_COUNT][WORD_MAX] = '{
      '{"a", "n", "d", 8'h00, 8'h00, 8'h00},
      '{"c", "l", "a", "s", "s", 8'h00},
      '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"e", "l", "s", "e", 8'h00, 8'h00},
      '{"e", "l", "i", "f", 8'h00, 8'h00},
      '{"t", "r", "u", "e", 8'h00, 8'h00},
      '{"f", "a", "l", "s", "e", 8'h00},
      '{"f", "u", "n", "c", 8'h00, 8'h00},
      '{"f", "o", "r", 8'h00, 8'h00, 8'h00},
      '{"w", "h", "i", "l", "e", 8'h00},
      '{"n", "u", "l", "l", 8'h00, 8'h00},
      '{"o", "r", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"p", "r", "i", "n", "t", 8'h00},
      '{"r", "e", "t", "u", "r", "n"},
      '{"t", "h", "i", "s", 8'h00, 8'h00},
      '{"s", "u", "p", "e", "r", 8'h00},
      '{"v", "a", "r", 8'h00, 8'h00, 8'h00}
   };

   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd3, 3'd5, 3'd2, 3'd4, 3'd4, 3'd4, 3'd5, 3'd4, 3'd3,
      3'd5, 3'd4, 3'd2, 3'd5, 3'd6, 3'd4, 3'd5, 3'd3
   };

   function automatic logic is_word_char(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
             (c >= "0" && c <= "9") || c == "_";
   endfunction

   // parallel compare of the buffered word against every keyword
   function automatic match_type kw_match(input word_type chars,
                                          input logic [2:0] len);
      match_type m;
      logic      same;
      m = '0;
      for (int k = 0; k < KW_COUNT; k++) begin
         same = (len == KW_LEN[k]);
         for (int i = 0; i < WORD_MAX; i++) begin
            if (3'(i) < len && chars[i] != KW_CHARS[k][i]) begin
               same = 1'b0;
            end
         end
         if (same) begin
            m.hit = 1'b1;
            m.idx = KW_IDX_BITS'(k);
         end
      end
      return m;
   endfunction

endpackage

`default_nettype wire

[design/kslex_front.sv]
// Lexer front end: takes one byte a cycle while take is high, tracks lexer
// mode and word buffer, and forms the bundle a byte causes. Uses kslex_pkg.
`default_nettype none

module kslex_front #(
   parameter int COLUMN_BITS = kslex_pkg::COLUMN_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   take,
   input  wire logic [7:0]             ch,
   input  wire logic                   end_of_code,
   output logic                        bundle_push,
   output kslex_pkg::bundle_type       bundle,
   output logic [COLUMN_BITS-1:0]      column
);
   import kslex_pkg::*;

   mode_type               mode_ff, mode_in, mode_mid;
   logic [2:0]             wlen_ff, wlen_in, wlen_mid;
   word_type               chars_ff, chars_mid;
   logic [COLUMN_BITS-1:0] idx_ff, idx_in;
   logic                   do_idle;

   logic       c_space, c_nl, c_quote, c_word, idle_err;
   match_type  cur_match, mid_match;

   assign c_space  = (ch == CH_SPACE);
   assign c_nl     = (ch == CH_NL);
   assign c_quote  = (ch == CH_QUOTE);
   assign c_word   = is_word_char(ch);
   assign idle_err = !(c_space || c_nl || c_quote || c_word);

   assign cur_match = kw_match(chars_ff, wlen_ff);
   assign mid_match = kw_match(chars_mid, wlen_mid);

   // next state of the lexer, before end-of-code handling
   always_comb begin
      mode_mid  = mode_ff;
      wlen_mid  = wlen_ff;
      chars_mid = chars_ff;
      do_idle   = 1'b0;
      case (mode_ff)
         MODE_IDLE: begin
            do_idle = 1'b1;
         end
         MODE_STR: begin
            if (c_quote) begin
               mode_mid = MODE_IDLE;
            end else if (c_nl) begin
               mode_mid = MODE_DRAIN;
            end
         end
         MODE_WORD: begin
            if (c_word) begin
               if (wlen_ff < 3'(WORD_MAX)) begin
                  chars_mid[wlen_ff] = ch;
                  wlen_mid           = wlen_ff + 3'd1;
               end else begin
                  wlen_mid = WLEN_LONG;
               end
            end else begin
               wlen_mid = 3'd0;
               if (cur_match.hit) begin
                  mode_mid = MODE_IDLE;
                  do_idle  = 1'b1;
               end else begin
                  mode_mid = MODE_DRAIN;
               end
            end
         end
         default: begin
         end
      endcase
      if (do_idle) begin
         if (c_space || c_nl) begin
            mode_mid = MODE_IDLE;
         end else if (c_quote) begin
            mode_mid = MODE_STR;
         end else if (c_word) begin
            chars_mid[0] = ch;
            wlen_mid     = 3'd1;
            mode_mid     = MODE_WORD;
         end else begin
            mode_mid = MODE_DRAIN;
         end
      end
   end

   always_comb begin
      if (end_of_code) begin
         mode_in = MODE_IDLE;
         wlen_in = 3'd0;
         idx_in  = '0;
      end else begin
         mode_in = mode_mid;
         wlen_in = wlen_mid;
         idx_in  = (&idx_ff) ? idx_ff : idx_ff + 1'b1;
      end
   end

   // results of this byte, in emission order
   always_comb begin
      logic [1:0] n;
      n      = 2'd0;
      bundle = '0;
      case (mode_ff)
         MODE_IDLE: begin
            if (idle_err) begin
               bundle.res[n] = '{K_ERROR, 8'd0, E_CHAR};
               n = n + 2'd1;
            end
         end
         MODE_STR: begin
            if (c_quote) begin
               bundle.res[n] = '{K_STREND, 8'd0, E_NONE};
            end else if (c_nl) begin
               bundle.res[n] = '{K_ERROR, 8'd0, E_UNTERM};
            end else begin
               bundle.res[n] = '{K_CHAR, ch, E_NONE};
            end
            n = n + 2'd1;
         end
         MODE_WORD: begin
            if (!c_word) begin
               if (cur_match.hit) begin
                  bundle.res[n] = '{K_KEYWORD, 8'(cur_match.idx), E_NONE};
                  n = n + 2'd1;
                  if (idle_err) begin
                     bundle.res[n] = '{K_ERROR, 8'd0, E_CHAR};
                     n = n + 2'd1;
                  end
               end else begin
                  bundle.res[n] = '{K_ERROR, 8'd0, E_WORD};
                  n = n + 2'd1;
               end
            end
         end
         default: begin
         end
      endcase
      if (end_of_code) begin
         if (mode_mid == MODE_STR) begin
            bundle.res[n] = '{K_ERROR, 8'd0, E_UNTERM};
            n = n + 2'd1;
         end else if (mode_mid == MODE_WORD) begin
            if (mid_match.hit) begin
               bundle.res[n] = '{K_KEYWORD, 8'(mid_match.idx), E_NONE};
            end else begin
               bundle.res[n] = '{K_ERROR, 8'd0, E_WORD};
            end
            n = n + 2'd1;
         end
         bundle.res[n] = '{K_END, 8'd0, E_NONE};
         n = n + 2'd1;
      end
      bundle.count = n;
   end

   assign bundle_push = take && (bundle.count != 2'd0);
   assign column      = idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         wlen_ff <= 3'd0;
         idx_ff  <= '0;
      end else if (take) begin
         mode_ff <= mode_in;
         wlen_ff <= wlen_in;
         idx_ff  <= idx_in;
      end
   end

   // word buffer is payload: contents only matter below wlen_ff
   always_ff @(posedge clock) begin
      if (take) begin
         chars_ff <= chars_mid;
      end
   end

endmodule

`default_nettype wire

[design/kslex_fifo.sv]
// Short queue of result bundles between the lexer front end and the result
// serialiser. Uses kslex_pkg.
`default_nettype none

module kslex_fifo #(
   parameter int COLUMN_BITS = kslex_pkg::COLUMN_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire kslex_pkg::bundle_type  push_bundle,
   input  wire logic [COLUMN_BITS-1:0] push_column,
   input  wire logic                   pop,
   output kslex_pkg::bundle_type       head_bundle,
   output logic [COLUMN_BITS-1:0]      head_column,
   output logic                        empty,
   output logic                        full
);
   import kslex_pkg::*;

   bundle_type             bundle_mem [Q_DEPTH];
   logic [COLUMN_BITS-1:0] column_mem [Q_DEPTH];
   logic [Q_PTR_BITS-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [Q_PTR_BITS:0]    cnt_ff, cnt_in;
   logic                   do_push, do_pop;

   assign empty   = (cnt_ff == '0);
   assign full    = (cnt_ff == (Q_PTR_BITS+1)'(Q_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   assign head_bundle = bundle_mem[rd_ff];
   assign head_column = column_mem[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         bundle_mem[wr_ff] <= push_bundle;
         column_mem[wr_ff] <= push_column;
      end
   end

endmodule

`default_nettype wire

[design/kslex_back.sv]
// Result serialiser: hands out the results of the head bundle one per
// transfer and retires the bundle after its last one. Uses kslex_pkg.
`default_nettype none

module kslex_back #(
   parameter int COLUMN_BITS = kslex_pkg::COLUMN_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire kslex_pkg::bundle_type  head_bundle,
   input  wire logic [COLUMN_BITS-1:0] head_column,
   input  wire logic                   q_empty,
   output logic                        q_pop,
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop,
   output logic [2:0]                  rsp_kind,
   output logic [7:0]                  rsp_value,
   output logic [1:0]                  rsp_err_code,
   output logic [COLUMN_BITS-1:0]      rsp_column,
   output logic                        rsp_last
);
   import kslex_pkg::*;

   logic [1:0] sub_ff, sub_in;
   result_type cur;
   logic       xfer;

   assign cur          = head_bundle.res[sub_ff];
   assign rsp_empty    = q_empty;
   assign rsp_kind     = cur.kind;
   assign rsp_value    = cur.value;
   assign rsp_err_code = cur.err_code;
   assign rsp_column   = head_column;
   assign rsp_last     = (sub_ff == head_bundle.count - 2'd1);

   assign xfer  = rsp_pop && !q_empty;
   assign q_pop = xfer && rsp_last;

   always_comb begin
      sub_in = sub_ff;
      if (xfer) begin
         sub_in = rsp_last ? 2'd0 : sub_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff <= 2'd0;
      end else begin
         sub_ff <= sub_in;
      end
   end

endmodule

`default_nettype wire

[design/keyword_string_lexer.sv]
// Keyword and string lexer top level: front end, bundle queue, serialiser.
// Depends on kslex_pkg, kslex_front, kslex_fifo and kslex_back.
//
// Usage:
//   Input channel: one source byte per transfer (req_push while req_full is
//   low), req_end_of_code marking the final byte of the code.
//   Result channel: the oldest result is on rsp_* while rsp_empty is low and
//   is taken by rsp_pop. rsp_last flags the final result a byte causes.
//   Every byte is lexed in the cycle it is transferred, so a byte is taken
//   each cycle while req_full is low; its results are queued as it is taken.
//   Bytes that give no result (word characters, blanks) leave no trace on
//   the output; a byte gives at most three results, delivered one per cycle
//   while rsp_pop is high. A four-bundle queue sits between front end and
//   serialiser: when the receiver stalls, bytes keep flowing until the queue
//   fills, then req_full rises. The keyword match is a combinational compare
//   against the 17-entry table in the front end.
//   Reset empties the queue and puts the lexer in idle at column zero; the
//   lexer then returns to idle at column zero after every end-of-code byte.
`default_nettype none

module keyword_string_lexer #(
   parameter int COLUMN_BITS = kslex_pkg::COLUMN_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_push,
   output logic                        req_full,
   input  wire logic [7:0]             req_ch,
   input  wire logic                   req_end_of_code,
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop,
   output logic [2:0]                  rsp_kind,
   output logic [7:0]                  rsp_value,
   output logic [1:0]                  rsp_err_code,
   output logic [COLUMN_BITS-1:0]      rsp_column,
   output logic                        rsp_last
);
   import kslex_pkg::*;

   logic                   take;
   logic                   bundle_push;
   bundle_type             bundle;
   logic [COLUMN_BITS-1:0] column;
   bundle_type             head_bundle;
   logic [COLUMN_BITS-1:0] head_column;
   logic                   q_empty, q_full, q_pop;

   assign req_full = q_full;
   assign take     = req_push && !q_full;

   kslex_front #(.COLUMN_BITS(COLUMN_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .ch          (req_ch),
      .end_of_code (req_end_of_code),
      .bundle_push (bundle_push),
      .bundle      (bundle),
      .column      (column)
   );

   kslex_fifo #(.COLUMN_BITS(COLUMN_BITS)) u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (bundle_push),
      .push_bundle (bundle),
      .push_column (column),
      .pop         (q_pop),
      .head_bundle (head_bundle),
      .head_column (head_column),
      .empty       (q_empty),
      .full        (q_full)
   );

   kslex_back #(.COLUMN_BITS(COLUMN_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_bundle  (head_bundle),
      .head_column  (head_column),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_kind     (rsp_kind),
      .rsp_value    (rsp_value),
      .rsp_err_code (rsp_err_code),
      .rsp_column   (rsp_column),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire

[design/kslex_checker.sv]
// Port-level checks for keyword_string_lexer, bound to the top level.
// Uses kslex_pkg.
`default_nettype none

module kslex_checker #(
   parameter int COLUMN_BITS = kslex_pkg::COLUMN_BITS_DEF
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_empty,
   input wire logic                   rsp_pop,
   input wire logic [2:0]             rsp_kind,
   input wire logic [7:0]             rsp_value,
   input wire logic [1:0]             rsp_err_code,
   input wire logic [COLUMN_BITS-1:0] rsp_column,
   input wire logic                   rsp_last
);
   import kslex_pkg::*;

   // nothing is waiting right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result waiting after reset");

   // error code set exactly on error results
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ((rsp_kind == K_ERROR) == (rsp_err_code != E_NONE)))
      else $error("error code does not match result kind");

   // end of code is always the final result of its byte
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == K_END) |-> rsp_last)
      else $error("end result not flagged last");

   // only string characters and keywords carry a value
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind != K_CHAR && rsp_kind != K_KEYWORD)
         |-> (rsp_value == 8'd0))
      else $error("non-zero value on valueless result");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_kind) && $stable(rsp_value) &&
          $stable(rsp_column) && $stable(rsp_last)))
      else $error("stalled result changed");

endmodule

bind keyword_string_lexer kslex_checker #(.COLUMN_BITS(COLUMN_BITS)) u_kslex_checker (.*);

`default_nettype wire

[sim/keyword_string_lexer_tb.sv]
// Self-checking testbench for keyword_string_lexer: predicts the lexer's token
// stream from every byte transferred and checks each popped result against it.
// Depends on kslex_pkg and keyword_string_lexer.
`timescale 1ns / 1ps

module keyword_string_lexer_tb;
   import kslex_pkg::*;

   localparam int COL_W       = COLUMN_BITS_DEF;
   localparam int STALL_LIMIT = 2000;
   localparam int TAIL_CYCLES = 8;
   localparam int PHASE_ITEMS = 125;

   typedef struct packed {
      logic [2:0]       kind;
      logic [7:0]       value;
      logic [1:0]       err_code;
      logic [COL_W-1:0] column;
      logic             last;
   } token_type;

   class token_scoreboard;
      token_type        expected_tokens[$];
      mode_type         mode;
      logic [7:0]       word_buf[WORD_MAX];
      logic [2:0]       word_len;
      logic [COL_W-1:0] byte_idx;
      int               mismatches;

      function new();
         mode       = MODE_IDLE;
         word_len   = '0;
         byte_idx   = '0;
         mismatches = 0;
      endfunction

      static function string keyword_text(int k);
         case (k)
            0:  return "and";
            1:  return "class";
            2:  return "if";
            3:  return "else";
            4:  return "elif";
            5:  return "true";
            6:  return "false";
            7:  return "func";
            8:  return "for";
            9:  return "while";
            10: return "null";
            11: return "or";
            12: return "print";
            13: return "return";
            14: return "this";
            15: return "super";
            default: return "var";
         endcase
      endfunction

      static function bit word_char(logic [7:0] c);
         return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
                (c >= 8'h30 && c <= 8'h39) || c == 8'h5F;
      endfunction

      function void emit(logic [2:0] kind, logic [7:0] value, logic [1:0] err,
                         logic [COL_W-1:0] col);
         token_type t;
         t.kind     = kind;
         t.value    = value;
         t.err_code = err;
         t.column   = col;
         t.last     = 1'b0;
         expected_tokens.insert(expected_tokens.size(), t);
      endfunction

      function int lookup_word();
         string kw;
         bit    same;
         if (word_len > WORD_MAX) return -1;
         for (int k = 0; k < KW_COUNT; k++) begin
            kw = keyword_text(k);
            if (kw.len() != word_len) continue;
            same = 1'b1;
            for (int i = 0; i < word_len; i++) begin
               if (word_buf[i] != kw[i]) same = 1'b0;
            end
            if (same) return k;
         end
         return -1;
      endfunction

      // keyword sends the lexer back to idle, anything else drains
      function bit close_word(logic [COL_W-1:0] col);
         int idx;
         idx      = lookup_word();
         word_len = '0;
         if (idx >= 0) begin
            emit(K_KEYWORD, 8'(idx), E_NONE, col);
            mode = MODE_IDLE;
            return 1'b1;
         end
         emit(K_ERROR, 8'h00, E_WORD, col);
         mode = MODE_DRAIN;
         return 1'b0;
      endfunction

      function void start_token(logic [7:0] c, logic [COL_W-1:0] col);
         if (c == CH_SPACE || c == CH_NL) begin
            mode = MODE_IDLE;
         end else if (c == CH_QUOTE) begin
            mode = MODE_STR;
         end else if (word_char(c)) begin
            word_buf[0] = c;
            word_len    = 3'd1;
            mode        = MODE_WORD;
         end else begin
            emit(K_ERROR, 8'h00, E_CHAR, col);
            mode = MODE_DRAIN;
         end
      endfunction

      function void lex_byte(logic [7:0] c, logic eoc);
         logic [COL_W-1:0] col;
         int               first;
         col   = byte_idx;
         first = expected_tokens.size();
         case (mode)
            MODE_IDLE: start_token(c, col);
            MODE_STR: begin
               if (c == CH_QUOTE) begin
                  emit(K_STREND, 8'h00, E_NONE, col);
                  mode = MODE_IDLE;
               end else if (c == CH_NL) begin
                  emit(K_ERROR, 8'h00, E_UNTERM, col);
                  mode = MODE_DRAIN;
               end else begin
                  emit(K_CHAR, c, E_NONE, col);
               end
            end
            MODE_WORD: begin
               if (word_char(c)) begin
                  if (word_len < WORD_MAX) begin
                     word_buf[word_len] = c;
                     word_len++;
                  end else begin
                     word_len = WLEN_LONG;
                  end
               end else if (close_word(col)) begin
                  start_token(c, col);
               end
            end
            default: ;
         endcase
         if (eoc) begin
            if (mode == MODE_STR) emit(K_ERROR, 8'h00, E_UNTERM, col);
            else if (mode == MODE_WORD) void'(close_word(col));
            emit(K_END, 8'h00, E_NONE, col);
            mode     = MODE_IDLE;
            word_len = '0;
            byte_idx = '0;
         end else if (byte_idx != '1) begin
            byte_idx++;
         end
         if (expected_tokens.size() > first)
            expected_tokens[expected_tokens.size()-1].last = 1'b1;
      endfunction

      function void note_mismatch(string what, token_type want, token_type got);
         mismatches++;
         if (mismatches <= 10) begin
            $write("%0t: %s: expected kind %0d value %0h err %0d col %0d last %0d, ",
                   $realtime, what, want.kind, want.value, want.err_code,
                   want.column, want.last);
            $display("got kind %0d value %0h err %0d col %0d last %0d",
                     got.kind, got.value, got.err_code, got.column, got.last);
         end
      endfunction

      function void check_token(token_type got);
         token_type want;
         if (expected_tokens.size() == 0) begin
            note_mismatch("result with nothing pending", '0, got);
            return;
         end
         want = expected_tokens.pop_front();
         if (got.kind !== want.kind || got.value !== want.value ||
             got.err_code !== want.err_code || got.column !== want.column ||
             got.last !== want.last)
            note_mismatch("wrong result", want, got);
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_push = 1'b0;
   logic             req_full;
   logic [7:0]       req_ch = 8'h00;
   logic             req_end_of_code = 1'b0;
   logic             rsp_empty;
   logic             rsp_pop = 1'b0;
   logic [2:0]       rsp_kind;
   logic [7:0]       rsp_value;
   logic [1:0]       rsp_err_code;
   logic [COL_W-1:0] rsp_column;
   logic             rsp_last;

   token_scoreboard  sb = new();
   logic [7:0]       code_bytes[$];
   int               send_idle = 0;
   int               recv_stall = 0;
   int               sent_items = 0;
   int               quiet_cycles = 0;

   keyword_string_lexer #(.COLUMN_BITS(COL_W)) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_ch          (req_ch),
      .req_end_of_code (req_end_of_code),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_kind        (rsp_kind),
      .rsp_value       (rsp_value),
      .rsp_err_code    (rsp_err_code),
      .rsp_column      (rsp_column),
      .rsp_last        (rsp_last)
   );

   always #1 clock = ~clock;

   // monitors read pre-edge values; all drives are nonblocking
   always @(posedge clock) begin
      if (!reset && req_push && !req_full) sb.lex_byte(req_ch, req_end_of_code);
      if (!reset && rsp_pop && !rsp_empty)
         sb.check_token(token_type'{rsp_kind, rsp_value, rsp_err_code, rsp_column,
                                    rsp_last});
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial forever begin
      @(posedge clock);
      rsp_pop <= ($urandom_range(99) >= recv_stall);
   end

   task automatic send_byte(input logic [7:0] c, input logic eoc);
      while ($urandom_range(99) < send_idle) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push        <= 1'b1;
      req_ch          <= c;
      req_end_of_code <= eoc;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sent_items++;
   endtask

   // the final byte of the buffered code carries the end flag
   task automatic send_code();
      foreach (code_bytes[i]) send_byte(code_bytes[i], i == code_bytes.size() - 1);
      code_bytes.delete();
   endtask

   task automatic drain_results();
      req_push <= 1'b0;
      @(posedge clock);
      while (sb.expected_tokens.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   function automatic void add_byte(logic [7:0] c);
      code_bytes.insert(code_bytes.size(), c);
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   function automatic logic [7:0] random_word_char();
      int r;
      r = $urandom_range(62);
      if (r < 26) return 8'(8'h61 + r);
      if (r < 52) return 8'(8'h41 + r - 26);
      if (r < 62) return 8'(8'h30 + r - 52);
      return 8'h5F;
   endfunction

   function automatic logic [7:0] random_string_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (c == CH_QUOTE || c == CH_NL);
      return c;
   endfunction

   // mostly well-formed code; one in five may carry broken tokens
   function automatic void build_random_code();
      int  tokens;
      int  pick;
      bit  clean;
      clean  = ($urandom_range(4) != 0);
      tokens = $urandom_range(1, 6);
      for (int t = 0; t < tokens; t++) begin
         pick = clean ? $urandom_range(79) : $urandom_range(99);
         if (pick < 40) begin
            add_text(token_scoreboard::keyword_text($urandom_range(KW_COUNT - 1)));
            case ($urandom_range(5))
               0, 1, 2: add_byte(CH_SPACE);
               3:       add_byte(CH_NL);
               default: ;
            endcase
         end else if (pick < 70) begin
            add_byte(CH_QUOTE);
            repeat ($urandom_range(6)) add_byte(random_string_byte());
            add_byte(CH_QUOTE);
         end else if (pick < 80) begin
            repeat ($urandom_range(1, 3))
               add_byte($urandom_range(1) ? CH_SPACE : CH_NL);
         end else if (pick < 88) begin
            repeat ($urandom_range(1, 9)) add_byte(random_word_char());
         end else if (pick < 95) begin
            add_byte(8'($urandom_range(255)));
         end else begin
            // unterminated literal: newline inside or end of code inside
            add_byte(CH_QUOTE);
            repeat ($urandom_range(3)) add_byte(random_string_byte());
            if ($urandom_range(1)) add_byte(CH_NL);
         end
      end
   endfunction

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: keyword closed by a quote, string, string end at end of code
      add_text("if\"x\"");
      send_code();
      // newline inside a literal, then drain, extreme byte values
      add_byte(CH_QUOTE);
      add_byte(8'hFF);
      add_byte(CH_NL);
      add_byte(8'h00);
      send_code();
      add_text("\"A");          // end of code inside a literal
      send_code();
      add_text("returns");      // over-long word closed by end of code
      send_code();
      add_text("x\"");          // unknown word, closing byte ignored
      send_code();
      add_text("@");
      send_code();
      add_text(" ");
      send_code();
      add_text("or");
      send_code();

      // three results from a single byte
      add_text("\"z\"if!");
      send_code();
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 66; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 66; end
            default: begin send_idle = 38; recv_stall = 38; end
         endcase
         sent_items = 0;
         while (sent_items < PHASE_ITEMS) begin
            build_random_code();
            send_code();
         end
         drain_results();
      end

      send_idle  = 0;
      recv_stall = 0;
      drain_results();
      if (sb.mismatches == 0 && sb.expected_tokens.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
